FILE: rtl/core/edge_swipe_back_gesture_unit_macros.svh
// ----------------------------------------------------------------------------
// Edge swipe back gesture unit assertion macros
// Shared concurrent assertion forms for the gesture unit checkers.
// ----------------------------------------------------------------------------
`ifndef EDGE_SWIPE_BACK_GESTURE_UNIT_MACROS_SVH
`define EDGE_SWIPE_BACK_GESTURE_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ESBG_ASSERT_IMPL(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("gesture unit check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ESBG_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("gesture unit check failed");

// Next-cycle implication that is also checked across reset.
`define ESBG_ASSERT_NEXT_ALWAYS(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) (cond) |=> (prop)) \
        else $error("gesture unit check failed");

`endif

FILE: rtl/core/esbg_pkg.sv
// ----------------------------------------------------------------------------
// Edge swipe back gesture package
// Constants, register codes and shared types of the gesture unit.
// ----------------------------------------------------------------------------
package esbg_pkg;

    localparam int COORD_BITS         = 12;
    localparam int SCR_BITS           = 13;
    localparam int INDICATOR_DIAMETER = 104;
    localparam int HINT_EDGE_WIDTH    = 16;
    localparam int ACT_EDGE           = 1;
    localparam int MAX_VIS            = INDICATOR_DIAMETER * 2 / 5;
    localparam int FULL_REVEAL        = MAX_VIS - ACT_EDGE;
    localparam int HALF_DIAM          = INDICATOR_DIAMETER / 2;
    localparam int GLYPH_INSET        = 4;
    localparam int OPA_MIN            = 150;
    localparam int OPA_MAX            = 230;

    localparam logic [SCR_BITS-1:0] SCREEN_RESET = 13'd480;

    localparam logic REG_SCR_WIDTH     = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic                  pressed;
        logic [COORD_BITS-1:0] touch_x;
        logic [COORD_BITS-1:0] touch_y;
        logic                  edge_hint;
    } sample_t;

    typedef struct packed {
        logic                  consumed;
        logic                  navigate_back;
        logic                  haptic_pulse;
        logic                  show;
        logic                  left;
        logic [5:0]            reach;
        logic [COORD_BITS-1:0] start_y;
    } gest_t;

    typedef struct packed {
        logic                       consumed;
        logic                       navigate_back;
        logic                       haptic_pulse;
        logic                       indicator_visible;
        logic [5:0]                 reveal_width;
        logic [7:0]                 opacity;
        logic signed [12:0]         clip_x;
        logic [COORD_BITS-1:0]      clip_y;
        logic signed [7:0]          disc_x;
        logic [6:0]                 glyph_x;
        logic                       points_right;
    } result_t;

endpackage

FILE: rtl/core/esbg_track.sv
// ----------------------------------------------------------------------------
// Edge swipe gesture tracker
// Holds the gesture state, detects edge starts, commits and releases.
// ----------------------------------------------------------------------------
module esbg_track
    import esbg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  sample_t             sample,
    input  logic [SCR_BITS-1:0] scr_width,
    output gest_t               gest
);

    logic                  press_seen_reg, press_seen_next;
    logic                  tracking_reg, tracking_next;
    logic                  armed_reg, armed_next;
    logic                  left_reg, left_next;
    logic                  right_reg, right_next;
    logic [COORD_BITS-1:0] start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;

    logic signed [13:0]    act;
    logic signed [13:0]    xs;
    logic signed [13:0]    right_lim;
    logic                  first_left, first_right;
    logic [SCR_BITS-1:0]   edge_x;
    logic [COORD_BITS-1:0] snap_right;
    logic                  eff_left, eff_right, eff_track;
    logic [COORD_BITS-1:0] eff_start;
    logic signed [13:0]    d;
    logic                  armed_new;

    function automatic logic signed [13:0] edge_hint_act(input logic hint);
        edge_hint_act = hint ? 14'(HINT_EDGE_WIDTH) : 14'(ACT_EDGE);
    endfunction

    always_comb begin
        act         = edge_hint_act(sample.edge_hint);
        xs          = signed'({2'b00, sample.touch_x});
        right_lim   = signed'({1'b0, scr_width}) - act;
        first_left  = xs < act;
        first_right = xs >= right_lim;
        edge_x      = scr_width - 13'd1;
        snap_right  = (edge_x > SCR_BITS'({COORD_BITS{1'b1}})) ? {COORD_BITS{1'b1}}
                                                               : edge_x[COORD_BITS-1:0];
        if (!press_seen_reg) begin
            eff_left  = first_left;
            eff_right = first_right;
            eff_track = first_left || first_right;
            if (sample.edge_hint && first_left) begin
                eff_start = '0;
            end else if (sample.edge_hint && first_right) begin
                eff_start = snap_right;
            end else begin
                eff_start = sample.touch_x;
            end
        end else begin
            eff_left  = left_reg;
            eff_right = right_reg;
            eff_track = tracking_reg;
            eff_start = start_x_reg;
        end
        if (eff_left) begin
            d = xs - signed'({2'b00, eff_start});
        end else if (eff_right) begin
            d = signed'({2'b00, eff_start}) - xs;
        end else begin
            d = '0;
        end
        armed_new = d >= 14'(FULL_REVEAL);
    end

    always_comb begin
        press_seen_next = press_seen_reg;
        tracking_next   = tracking_reg;
        armed_next      = armed_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        gest            = '0;
        gest.left       = eff_left;
        gest.start_y    = press_seen_reg ? start_y_reg : sample.touch_y;
        if (d < 0) begin
            gest.reach = '0;
        end else if (d >= 14'(FULL_REVEAL)) begin
            gest.reach = 6'(FULL_REVEAL);
        end else begin
            gest.reach = d[5:0];
        end
        if (!sample.pressed) begin
            gest.consumed      = tracking_reg;
            gest.navigate_back = tracking_reg && armed_reg;
            press_seen_next    = 1'b0;
            tracking_next      = 1'b0;
            armed_next         = 1'b0;
            left_next          = 1'b0;
            right_next         = 1'b0;
            start_x_next       = '0;
            start_y_next       = '0;
        end else if (scr_width == '0) begin
            gest.show = 1'b0;
        end else if (!press_seen_reg) begin
            press_seen_next = 1'b1;
            tracking_next   = eff_track;
            left_next       = eff_left;
            right_next      = eff_right;
            start_x_next    = eff_start;
            start_y_next    = sample.touch_y;
            if (eff_track) begin
                armed_next        = armed_new;
                gest.haptic_pulse = armed_new && !armed_reg;
                gest.show         = 1'b1;
                gest.consumed     = 1'b1;
            end
        end else if (tracking_reg) begin
            armed_next        = armed_new;
            gest.haptic_pulse = armed_new && !armed_reg;
            gest.show         = d >= 0;
            gest.consumed     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_seen_reg <= 1'b0;
            tracking_reg   <= 1'b0;
            armed_reg      <= 1'b0;
            left_reg       <= 1'b0;
            right_reg      <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
        end else if (step) begin
            press_seen_reg <= press_seen_next;
            tracking_reg   <= tracking_next;
            armed_reg      <= armed_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
        end
    end

endmodule

FILE: rtl/core/esbg_geom.sv
// ----------------------------------------------------------------------------
// Edge swipe indicator geometry
// Turns the gesture decision into indicator size, opacity and placement.
// ----------------------------------------------------------------------------
module esbg_geom
    import esbg_pkg::*;
(
    input  gest_t               gest,
    input  logic [SCR_BITS-1:0] scr_width,
    input  logic [SCR_BITS-1:0] screen_height,
    output result_t             res
);

    logic [5:0]         vis;
    logic [5:0]         vis_half;
    logic signed [13:0] hi;
    logic signed [13:0] sy;
    logic signed [13:0] cy;

    always_comb begin
        vis      = gest.reach + 6'(ACT_EDGE);
        vis_half = vis >> 1;
        hi       = signed'({1'b0, screen_height}) - 14'(HALF_DIAM);
        if (hi < 14'(HALF_DIAM)) begin
            hi = 14'(HALF_DIAM);
        end
        sy = signed'({2'b00, gest.start_y});
        if (sy < 14'(HALF_DIAM)) begin
            cy = 14'(HALF_DIAM);
        end else if (sy > hi) begin
            cy = hi;
        end else begin
            cy = sy;
        end

        res               = '0;
        res.consumed      = gest.consumed;
        res.navigate_back = gest.navigate_back;
        res.haptic_pulse  = gest.haptic_pulse;
        if (gest.show) begin
            res.indicator_visible = 1'b1;
            res.reveal_width      = vis;
            res.opacity           = 8'(OPA_MIN) + {1'b0, gest.reach, 1'b0};
            res.clip_y            = COORD_BITS'(cy - 14'(HALF_DIAM));
            res.points_right      = gest.left;
            if (gest.left) begin
                res.clip_x  = '0;
                res.disc_x  = signed'({2'b00, vis} - 8'(INDICATOR_DIAMETER));
                res.glyph_x = 7'(INDICATOR_DIAMETER - GLYPH_INSET)
                              - 7'(vis - vis_half);
            end else begin
                res.clip_x  = signed'(scr_width - {7'd0, vis});
                res.disc_x  = '0;
                res.glyph_x = {1'b0, vis_half} + 7'(GLYPH_INSET);
            end
        end
    end

endmodule

FILE: rtl/core/edge_swipe_back_gesture_unit.sv
// ----------------------------------------------------------------------------
// Edge swipe back gesture unit
// A sample is registered in in_data_reg on its input transfer; its result is registered in out_data_reg for m_tdata.
// Throughput: one sample per cycle while m_tready does not stall the output, through one pass between two registers.
// Reset (aresetn low, synchronous) clears state, valids, sets sizes to 480.
// ----------------------------------------------------------------------------
module edge_swipe_back_gesture_unit
    import esbg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: pressed, touch_x[11:0], touch_y[11:0], edge_hint, zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: consumed, navigate_back, haptic_pulse, indicator_visible,
    // reveal_width[5:0], opacity[7:0], clip_x[12:0], clip_y[11:0],
    // disc_x[7:0], glyph_x[6:0], points_right, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SCR_BITS-1:0] scr_width_reg;
    logic [SCR_BITS-1:0] screen_height_reg;
    logic                in_vld_reg;
    sample_t             in_data_reg;
    logic                out_vld_reg;
    logic [63:0]         out_data_reg, out_data_next;
    logic                step;
    logic                cfg_wr;
    gest_t               gest;
    result_t             res;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_SCREEN_HEIGHT) ? {19'd0, screen_height_reg}
                                                      : {19'd0, scr_width_reg};
    assign step     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_width_reg     <= SCREEN_RESET;
            screen_height_reg <= SCREEN_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SCR_WIDTH) begin
                scr_width_reg <= pwdata[SCR_BITS-1:0];
            end else begin
                screen_height_reg <= pwdata[SCR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (step) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg.pressed   <= s_tdata[0];
            in_data_reg.touch_x   <= s_tdata[12:1];
            in_data_reg.touch_y   <= s_tdata[24:13];
            in_data_reg.edge_hint <= s_tdata[25];
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    esbg_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .sample    (in_data_reg),
        .scr_width (scr_width_reg),
        .gest      (gest)
    );

    esbg_geom u_geom (
        .gest          (gest),
        .scr_width     (scr_width_reg),
        .screen_height (screen_height_reg),
        .res           (res)
    );

    assign out_data_next = {5'd0, res.points_right, res.glyph_x, res.disc_x,
                            res.clip_y, res.clip_x, res.opacity, res.reveal_width,
                            res.indicator_visible, res.haptic_pulse, res.navigate_back,
                            res.consumed};

endmodule

FILE: rtl/core/esbg_checker.sv
// ----------------------------------------------------------------------------
// Edge swipe back gesture checker
// Port-level checks on the result stream of the gesture unit.
// ----------------------------------------------------------------------------
`include "edge_swipe_back_gesture_unit_macros.svh"

module esbg_checker
    import esbg_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    `ESBG_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !aresetn, !m_tvalid)

    `ESBG_ASSERT_IMPL(a_hidden_geom_zero, m_tvalid && !m_tdata[3], m_tdata[58:4] == '0)

    `ESBG_ASSERT_IMPL(a_haptic_full, m_tvalid && m_tdata[2], m_tdata[3] && m_tdata[0] && (m_tdata[9:4] == 6'(MAX_VIS)))

    `ESBG_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind edge_swipe_back_gesture_unit esbg_checker u_esbg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
